// ===== rtl/tfv_pkg.sv =====
// ----------------------------------------------------------------------------
// tfv_pkg
// Shared types, constants and byte classification helpers for the text
// field validator.
// ----------------------------------------------------------------------------
package tfv_pkg;

  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int LENGTH_BITS_D = 16;

  typedef enum logic [1:0] {
    KIND_USER    = 2'd0,
    KIND_PASS    = 2'd1,
    KIND_MESSAGE = 2'd2,
    KIND_GROUP   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_USER_SHORT = 4'd1,
    ST_USER_LONG  = 4'd2,
    ST_USER_BAD   = 4'd3,
    ST_PASS_SHORT = 4'd4,
    ST_PASS_LONG  = 4'd5,
    ST_INVALID    = 4'd6,
    ST_MSG_EMPTY  = 4'd7,
    ST_MSG_LONG   = 4'd8
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USER_MIN  = 3'd0,
    REG_USER_MAX  = 3'd1,
    REG_PASS_MIN  = 3'd2,
    REG_PASS_MAX  = 3'd3,
    REG_MSG_MAX   = 3'd4,
    REG_GROUP_MIN = 3'd5,
    REG_GROUP_MAX = 3'd6
  } reg_idx_t;

  localparam logic [CFG_W-1:0] RST_USER_MIN  = 16'd3;
  localparam logic [CFG_W-1:0] RST_USER_MAX  = 16'd20;
  localparam logic [CFG_W-1:0] RST_PASS_MIN  = 16'd6;
  localparam logic [CFG_W-1:0] RST_PASS_MAX  = 16'd20;
  localparam logic [CFG_W-1:0] RST_MSG_MAX   = 16'd1000;
  localparam logic [CFG_W-1:0] RST_GROUP_MIN = 16'd1;
  localparam logic [CFG_W-1:0] RST_GROUP_MAX = 16'd50;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_USCR  = 8'h5F;
  localparam logic [7:0] CH_LO_P  = 8'h70;
  localparam logic [7:0] CH_LO_S  = 8'h73;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= 8'h41) && (b <= 8'h5A);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return is_upper(b) ? (b + 8'h20) : b;
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_upper(b) || ((b >= 8'h61) && (b <= 8'h7A)) ||
           ((b >= 8'h30) && (b <= 8'h39)) || (b == CH_USCR);
  endfunction

  function automatic logic is_ctrl(input logic [7:0] b);
    return ((b < 8'h20) || (b == CH_DEL)) &&
           (b != CH_TAB) && (b != CH_LF) && (b != CH_CR);
  endfunction

  // single-byte hazards
  function automatic logic is_danger_char(input logic [7:0] c);
    return (c == CH_SQUOT) || (c == CH_DQUOT) || (c == CH_SEMI) ||
           (c == CH_LT) || (c == CH_GT);
  endfunction

endpackage

// ===== rtl/tfv_if.sv =====
// ----------------------------------------------------------------------------
// tfv channel interfaces
// Valid/ready channels for field bytes, status results and register writes.
// ----------------------------------------------------------------------------
interface tfv_in_if;
  logic                valid;
  logic                ready;
  tfv_pkg::kind_t      field_kind;
  logic [7:0]          data_byte;
  logic                byte_present;
  logic                last;

  modport source (output valid, field_kind, data_byte, byte_present, last,
                  input  ready);
  modport sink   (input  valid, field_kind, data_byte, byte_present, last,
                  output ready);
endinterface

interface tfv_out_if;
  logic                valid;
  logic                ready;
  tfv_pkg::status_t    status;

  modport source (output valid, status, input ready);
  modport sink   (input  valid, status, output ready);
endinterface

interface tfv_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tfv_pkg::CFG_IDX_W-1:0] index;
  logic [tfv_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input  valid, index, data, output ready);
endinterface

// ===== rtl/text_field_validator.sv =====
// ----------------------------------------------------------------------------
// text_field_validator
// A last item's status is computed from the input register and held in the
// result register. Throughput: one item per cycle, set by the single pass
// from input register to result register; a stalled result only holds back
// last items. Reset (rst_n low, synchronous) empties both registers, clears
// the field state and loads the default limits.
// ----------------------------------------------------------------------------
module text_field_validator #(
  parameter int LENGTH_BITS = tfv_pkg::LENGTH_BITS_D
) (
  input  logic          clk,
  input  logic          rst_n,
  tfv_in_if.sink        in_if,
  tfv_out_if.source     out_if,
  tfv_cfg_if.sink       cfg_if
);

  localparam int CMP_W = (LENGTH_BITS > tfv_pkg::CFG_W) ? LENGTH_BITS : tfv_pkg::CFG_W;
  localparam logic [LENGTH_BITS-1:0] LEN_TOP = {LENGTH_BITS{1'b1}};

  // limits
  logic [tfv_pkg::CFG_W-1:0] user_min_r, user_max_r, pass_min_r, pass_max_r;
  logic [tfv_pkg::CFG_W-1:0] msg_max_r, group_min_r, group_max_r;

  // input register
  logic               in_valid_r;
  tfv_pkg::kind_t     in_kind_r;
  logic [7:0]         in_byte_r;
  logic               in_present_r;
  logic               in_last_r;

  // field state
  logic [7:0]             prev_r, prev2_r;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;
  logic                   danger_r, danger_nxt;
  logic                   class_r, class_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  tfv_pkg::status_t   status_r, status_nxt;

  logic               s1_go;
  logic               in_ready;
  logic [7:0]         low_c;
  logic [CMP_W-1:0]   n;

  assign s1_go    = in_valid_r && (!in_last_r || !out_valid_r || out_if.ready);
  assign in_ready = !in_valid_r || s1_go;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid  = out_valid_r;
  assign out_if.status = status_r;

  assign low_c = tfv_pkg::to_lower(in_byte_r);
  assign n     = CMP_W'(cnt_nxt);

  always_comb begin
    cnt_nxt    = cnt_r;
    danger_nxt = danger_r;
    class_nxt  = class_r;
    if (in_present_r) begin
      if (tfv_pkg::is_danger_char(low_c)) danger_nxt = 1'b1;
      if ((prev_r == tfv_pkg::CH_DASH  && low_c == tfv_pkg::CH_DASH) ||
          (prev_r == tfv_pkg::CH_SLASH && low_c == tfv_pkg::CH_STAR) ||
          (prev_r == tfv_pkg::CH_STAR  && low_c == tfv_pkg::CH_SLASH)) danger_nxt = 1'b1;
      if ((prev2_r == tfv_pkg::CH_LO_X || prev2_r == tfv_pkg::CH_LO_S) &&
          prev_r == tfv_pkg::CH_LO_P && low_c == tfv_pkg::CH_USCR) danger_nxt = 1'b1;
      if (tfv_pkg::is_ctrl(in_byte_r)) danger_nxt = 1'b1;
      if (!tfv_pkg::is_word(in_byte_r)) class_nxt = 1'b1;
      if (cnt_r != LEN_TOP) cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    status_nxt = tfv_pkg::ST_OK;
    unique case (in_kind_r)
      tfv_pkg::KIND_USER: begin
        priority if (n < CMP_W'(user_min_r)) status_nxt = tfv_pkg::ST_USER_SHORT;
        else if (n > CMP_W'(user_max_r))     status_nxt = tfv_pkg::ST_USER_LONG;
        else if (n == '0 || class_nxt || danger_nxt) status_nxt = tfv_pkg::ST_USER_BAD;
        else                                 status_nxt = tfv_pkg::ST_OK;
      end
      tfv_pkg::KIND_PASS: begin
        priority if (n < CMP_W'(pass_min_r)) status_nxt = tfv_pkg::ST_PASS_SHORT;
        else if (n > CMP_W'(pass_max_r))     status_nxt = tfv_pkg::ST_PASS_LONG;
        else if (danger_nxt)                 status_nxt = tfv_pkg::ST_INVALID;
        else                                 status_nxt = tfv_pkg::ST_OK;
      end
      tfv_pkg::KIND_MESSAGE: begin
        priority if (n == '0)               status_nxt = tfv_pkg::ST_MSG_EMPTY;
        else if (n > CMP_W'(msg_max_r))     status_nxt = tfv_pkg::ST_MSG_LONG;
        else if (danger_nxt)                status_nxt = tfv_pkg::ST_INVALID;
        else                                status_nxt = tfv_pkg::ST_OK;
      end
      tfv_pkg::KIND_GROUP: begin
        if (n < CMP_W'(group_min_r) || n > CMP_W'(group_max_r) || danger_nxt) begin
          status_nxt = tfv_pkg::ST_INVALID;
        end else begin
          status_nxt = tfv_pkg::ST_OK;
        end
      end
      default: status_nxt = tfv_pkg::ST_OK;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && in_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and field state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      prev2_r     <= '0;
      cnt_r       <= '0;
      danger_r    <= 1'b0;
      class_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_ready) begin
        in_valid_r <= in_if.valid;
      end
      if (s1_go) begin
        if (in_last_r) begin
          prev_r   <= '0;
          prev2_r  <= '0;
          cnt_r    <= '0;
          danger_r <= 1'b0;
          class_r  <= 1'b0;
        end else if (in_present_r) begin
          prev2_r  <= prev_r;
          prev_r   <= low_c;
          cnt_r    <= cnt_nxt;
          danger_r <= danger_nxt;
          class_r  <= class_nxt;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_if.valid) begin
      in_kind_r    <= in_if.field_kind;
      in_byte_r    <= in_if.data_byte;
      in_present_r <= in_if.byte_present;
      in_last_r    <= in_if.last;
    end
    if (s1_go && in_last_r) begin
      status_r <= status_nxt;
    end
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_min_r  <= tfv_pkg::RST_USER_MIN;
      user_max_r  <= tfv_pkg::RST_USER_MAX;
      pass_min_r  <= tfv_pkg::RST_PASS_MIN;
      pass_max_r  <= tfv_pkg::RST_PASS_MAX;
      msg_max_r   <= tfv_pkg::RST_MSG_MAX;
      group_min_r <= tfv_pkg::RST_GROUP_MIN;
      group_max_r <= tfv_pkg::RST_GROUP_MAX;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        tfv_pkg::REG_USER_MIN:  user_min_r  <= cfg_if.data;
        tfv_pkg::REG_USER_MAX:  user_max_r  <= cfg_if.data;
        tfv_pkg::REG_PASS_MIN:  pass_min_r  <= cfg_if.data;
        tfv_pkg::REG_PASS_MAX:  pass_max_r  <= cfg_if.data;
        tfv_pkg::REG_MSG_MAX:   msg_max_r   <= cfg_if.data;
        tfv_pkg::REG_GROUP_MIN: group_min_r <= cfg_if.data;
        tfv_pkg::REG_GROUP_MAX: group_max_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  a_new_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(in_valid_r && in_last_r))
    else $error("result appeared without a last item");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r <= tfv_pkg::ST_MSG_LONG))
    else $error("status code out of range");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && in_last_r) |=> (cnt_r == '0 && !danger_r && !class_r && prev_r == '0))
    else $error("field state not cleared after last item");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !s1_go) |=> (in_valid_r && $stable(in_byte_r) && $stable(in_last_r)))
    else $error("input register lost a stalled item");

  a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == LEN_TOP && !(s1_go && in_last_r)) |=> (cnt_r == LEN_TOP))
    else $error("length counter wrapped");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_field_validator. A driver sends field items
// from a queue with random gaps and a monitor predicts each status, then
// compares it with the result channel under random back-pressure. The limit
// registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;

  typedef logic [tfv_pkg::CFG_W-1:0] limit_t;

  localparam logic [tfv_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int DRAIN_CAP = 200000;

  typedef struct packed {
    tfv_pkg::kind_t kind;
    logic [7:0]     data;
    logic           present;
    logic           last;
  } field_item_t;

  logic clk;
  logic rst_n;

  tfv_in_if  in_ch ();
  tfv_out_if out_ch ();
  tfv_cfg_if cfg_ch ();

  text_field_validator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  limit_t                            limit_reg [7];
  logic [7:0]                        prev_lc;
  logic [7:0]                        prev2_lc;
  logic [tfv_pkg::LENGTH_BITS_D-1:0] field_len;
  logic                              danger_hit;
  logic                              class_miss;

  field_item_t      item_q [$];
  tfv_pkg::status_t status_q [$];
  field_item_t      cur;
  int               mismatches = 0;
  bit               in_taken = 1'b0;
  bit               pace_on = 1'b0;
  int               send_gap = 0;
  int               stall_left = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic note_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // field predictor
  function automatic void clear_field();
    prev_lc    = 8'h00;
    prev2_lc   = 8'h00;
    field_len  = '0;
    danger_hit = 1'b0;
    class_miss = 1'b0;
  endfunction

  function automatic void take_char(logic [7:0] b);
    logic [7:0] c;
    c = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    if (c == tfv_pkg::CH_SQUOT || c == tfv_pkg::CH_DQUOT || c == tfv_pkg::CH_SEMI ||
        c == tfv_pkg::CH_LT || c == tfv_pkg::CH_GT)
      danger_hit = 1'b1;
    if ((prev_lc == tfv_pkg::CH_DASH && c == tfv_pkg::CH_DASH) ||
        (prev_lc == tfv_pkg::CH_SLASH && c == tfv_pkg::CH_STAR) ||
        (prev_lc == tfv_pkg::CH_STAR && c == tfv_pkg::CH_SLASH))
      danger_hit = 1'b1;
    if ((prev2_lc == tfv_pkg::CH_LO_X || prev2_lc == tfv_pkg::CH_LO_S) &&
        prev_lc == tfv_pkg::CH_LO_P && c == tfv_pkg::CH_USCR)
      danger_hit = 1'b1;
    if ((b < 8'h20 || b == tfv_pkg::CH_DEL) && b != tfv_pkg::CH_TAB &&
        b != tfv_pkg::CH_LF && b != tfv_pkg::CH_CR)
      danger_hit = 1'b1;
    if (!((c >= 8'h61 && c <= 8'h7A) || (b >= 8'h30 && b <= 8'h39) || b == tfv_pkg::CH_USCR))
      class_miss = 1'b1;
    if (field_len != '1) field_len++;
    prev2_lc = prev_lc;
    prev_lc  = c;
  endfunction

  function automatic tfv_pkg::status_t grade_field(tfv_pkg::kind_t k);
    case (k)
      tfv_pkg::KIND_USER: begin
        if (field_len < limit_reg[tfv_pkg::REG_USER_MIN]) return tfv_pkg::ST_USER_SHORT;
        if (field_len > limit_reg[tfv_pkg::REG_USER_MAX]) return tfv_pkg::ST_USER_LONG;
        if (field_len == 0 || class_miss || danger_hit) return tfv_pkg::ST_USER_BAD;
        return tfv_pkg::ST_OK;
      end
      tfv_pkg::KIND_PASS: begin
        if (field_len < limit_reg[tfv_pkg::REG_PASS_MIN]) return tfv_pkg::ST_PASS_SHORT;
        if (field_len > limit_reg[tfv_pkg::REG_PASS_MAX]) return tfv_pkg::ST_PASS_LONG;
        return danger_hit ? tfv_pkg::ST_INVALID : tfv_pkg::ST_OK;
      end
      tfv_pkg::KIND_MESSAGE: begin
        if (field_len == 0) return tfv_pkg::ST_MSG_EMPTY;
        if (field_len > limit_reg[tfv_pkg::REG_MSG_MAX]) return tfv_pkg::ST_MSG_LONG;
        return danger_hit ? tfv_pkg::ST_INVALID : tfv_pkg::ST_OK;
      end
      default: begin
        if (field_len < limit_reg[tfv_pkg::REG_GROUP_MIN] ||
            field_len > limit_reg[tfv_pkg::REG_GROUP_MAX])
          return tfv_pkg::ST_INVALID;
        return danger_hit ? tfv_pkg::ST_INVALID : tfv_pkg::ST_OK;
      end
    endcase
  endfunction

  // monitor
  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      limit_reg[tfv_pkg::REG_USER_MIN]  = tfv_pkg::RST_USER_MIN;
      limit_reg[tfv_pkg::REG_USER_MAX]  = tfv_pkg::RST_USER_MAX;
      limit_reg[tfv_pkg::REG_PASS_MIN]  = tfv_pkg::RST_PASS_MIN;
      limit_reg[tfv_pkg::REG_PASS_MAX]  = tfv_pkg::RST_PASS_MAX;
      limit_reg[tfv_pkg::REG_MSG_MAX]   = tfv_pkg::RST_MSG_MAX;
      limit_reg[tfv_pkg::REG_GROUP_MIN] = tfv_pkg::RST_GROUP_MIN;
      limit_reg[tfv_pkg::REG_GROUP_MAX] = tfv_pkg::RST_GROUP_MAX;
      clear_field();
      in_taken = 1'b0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (status_q.size() == 0) begin
          note_mismatch($sformatf("status %0d with none expected", out_ch.status));
        end else if (out_ch.status !== status_q[0]) begin
          note_mismatch($sformatf("status %0d, expected %0d", out_ch.status, status_q[0]));
          void'(status_q.pop_front());
        end else begin
          void'(status_q.pop_front());
        end
      end
      in_taken = (in_ch.valid === 1'b1 && in_ch.ready === 1'b1);
      if (in_taken) begin
        if (in_ch.byte_present) take_char(in_ch.data_byte);
        if (in_ch.last) begin
          status_q.push_back(grade_field(in_ch.field_kind));
          clear_field();
        end
      end
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1 &&
          cfg_ch.index <= tfv_pkg::REG_GROUP_MAX)
        limit_reg[cfg_ch.index] = cfg_ch.data;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n !== 1'b1) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid !== 1'b1 || in_taken) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else if (item_q.size() != 0) begin
        cur = item_q.pop_front();
        in_ch.field_kind   <= cur.kind;
        in_ch.data_byte    <= cur.data;
        in_ch.byte_present <= cur.present;
        in_ch.last         <= cur.last;
        in_ch.valid        <= 1'b1;
        send_gap = pace_on ? pick_pause() : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    if (rst_n !== 1'b1) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pace_on ? pick_pause() : 0;
    end
  end

  task automatic push_item(tfv_pkg::kind_t k, logic [7:0] b, logic pres, logic fin);
    item_q.push_back({k, b, pres, fin});
  endtask

  task automatic push_text(tfv_pkg::kind_t k, string s);
    for (int i = 0; i < s.len(); i++) push_item(k, s[i], 1'b1, i == s.len() - 1);
    if (s.len() == 0) push_item(k, 8'h00, 1'b0, 1'b1);
  endtask

  task automatic write_limit(logic [tfv_pkg::CFG_IDX_W-1:0] idx, limit_t val);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // wait for the sender and all results, then allow for items with no result
  task automatic drain();
    int n;
    n = 0;
    while ((item_q.size() != 0 || in_ch.valid !== 1'b0 || status_q.size() != 0) &&
           n < DRAIN_CAP) begin
      @(posedge clk);
      n++;
    end
    if (n >= DRAIN_CAP) note_mismatch($sformatf("%0d results missing", status_q.size()));
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] word_byte();
    case ($urandom_range(0, 3))
      0: return 8'h61 + 8'($urandom_range(0, 25));
      1: return 8'h41 + 8'($urandom_range(0, 25));
      2: return 8'h30 + 8'($urandom_range(0, 9));
      default: return tfv_pkg::CH_USCR;
    endcase
  endfunction

  function automatic logic [7:0] odd_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h1F;
      3: return tfv_pkg::CH_DEL;
      4: return 8'h80;
      5: return 8'hFF;
      6: return tfv_pkg::CH_TAB;
      7: return tfv_pkg::CH_LF;
      8: return tfv_pkg::CH_CR;
      default: return 8'h20;
    endcase
  endfunction

  function automatic string hazard_text(int n);
    case (n)
      0: return "'";
      1: return "\"";
      2: return ";";
      3: return "<";
      4: return ">";
      5: return "--";
      6: return "/*";
      7: return "*/";
      8: return "xp_";
      9: return "SP_";
      10: return "sP_";
      11: return "Xp_";
      12: return "-";
      13: return "/";
      14: return "*";
      15: return "x_p";
      16: return "p_";
      17: return "-/-";
      18: return "<script";
      19: return "*-/";
      default: return "xP";
    endcase
  endfunction

  function automatic limit_t pick_limit(int lo, int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return limit_t'($urandom_range(lo, hi));
  endfunction

  task automatic random_limits();
    write_limit(tfv_pkg::REG_USER_MIN, pick_limit(0, 8));
    write_limit(tfv_pkg::REG_USER_MAX, pick_limit(3, 30));
    write_limit(tfv_pkg::REG_PASS_MIN, pick_limit(0, 10));
    write_limit(tfv_pkg::REG_PASS_MAX, pick_limit(4, 30));
    write_limit(tfv_pkg::REG_MSG_MAX, pick_limit(1, 40));
    write_limit(tfv_pkg::REG_GROUP_MIN, pick_limit(0, 6));
    write_limit(tfv_pkg::REG_GROUP_MAX, pick_limit(2, 30));
  endtask

  // fields of word bytes, word bytes with hazards mixed in, or raw bytes
  task automatic random_round(int goal);
    logic [7:0]     txt [$];
    tfv_pkg::kind_t k;
    int             len;
    int             style;
    int             sent;
    bit             marker;
    string          h;
    sent = 0;
    while (sent < goal) begin
      txt.delete();
      k = tfv_pkg::kind_t'($urandom_range(0, 3));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 22);
      style = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) begin
        if (style >= 8) txt.push_back(8'($urandom_range(0, 255)));
        else txt.push_back(word_byte());
        if (style >= 4 && style < 8 && $urandom_range(0, len) == 0) begin
          if ($urandom_range(0, 1) == 1) begin
            h = hazard_text($urandom_range(0, 20));
            for (int j = 0; j < h.len(); j++) txt.push_back(h[j]);
          end else begin
            txt.push_back(odd_byte());
          end
        end
      end
      marker = (txt.size() == 0) || ($urandom_range(0, 4) == 0);
      foreach (txt[i]) begin
        if ($urandom_range(0, 11) == 0)
          push_item(tfv_pkg::kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'b0, 1'b0);
        push_item(($urandom_range(0, 9) == 0) ? tfv_pkg::kind_t'($urandom_range(0, 3)) : k,
                  txt[i], 1'b1, !marker && i == txt.size() - 1);
      end
      if (marker) push_item(k, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
      sent += txt.size() + marker;
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.field_kind   = tfv_pkg::KIND_USER;
    in_ch.data_byte    = 8'h00;
    in_ch.byte_present = 1'b0;
    in_ch.last         = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = tfv_pkg::REG_USER_MIN;
    cfg_ch.data        = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    pace_on = 1'b1;

    // default limits
    push_text(tfv_pkg::KIND_USER, "a_Z9");
    push_text(tfv_pkg::KIND_USER, "ab");
    push_text(tfv_pkg::KIND_USER, "ab-c");
    push_text(tfv_pkg::KIND_USER, "sP_x");
    push_text(tfv_pkg::KIND_PASS, "");
    push_text(tfv_pkg::KIND_PASS, "pw;word");
    push_text(tfv_pkg::KIND_MESSAGE, "");
    push_item(tfv_pkg::KIND_MESSAGE, tfv_pkg::CH_TAB, 1'b1, 1'b0);
    push_item(tfv_pkg::KIND_MESSAGE, tfv_pkg::CH_LF, 1'b1, 1'b0);
    push_item(tfv_pkg::KIND_MESSAGE, tfv_pkg::CH_CR, 1'b1, 1'b0);
    push_item(tfv_pkg::KIND_MESSAGE, 8'hFF, 1'b1, 1'b1);
    push_item(tfv_pkg::KIND_GROUP, 8'hFF, 1'b0, 1'b0);
    push_item(tfv_pkg::KIND_MESSAGE, 8'h00, 1'b1, 1'b1);
    push_text(tfv_pkg::KIND_MESSAGE, "a*/");
    push_text(tfv_pkg::KIND_GROUP, "x/*");
    push_text(tfv_pkg::KIND_GROUP, "a--");
    push_item(tfv_pkg::KIND_GROUP, tfv_pkg::CH_DEL, 1'b1, 1'b1);
    push_text(tfv_pkg::KIND_GROUP, "Xp_");
    push_item(tfv_pkg::KIND_MESSAGE, 8'h1F, 1'b1, 1'b0);
    push_item(tfv_pkg::KIND_PASS, 8'h00, 1'b0, 1'b1);
    drain();

    // extreme limits; the out-of-range index must change nothing
    write_limit(tfv_pkg::REG_USER_MIN, 16'h0000);
    write_limit(tfv_pkg::REG_USER_MAX, 16'hFFFF);
    write_limit(tfv_pkg::REG_PASS_MIN, 16'h0000);
    write_limit(tfv_pkg::REG_PASS_MAX, 16'hFFFF);
    write_limit(tfv_pkg::REG_MSG_MAX, 16'h0000);
    write_limit(tfv_pkg::REG_GROUP_MIN, 16'h0000);
    write_limit(tfv_pkg::REG_GROUP_MAX, 16'h0000);
    write_limit(REG_NONE, 16'h1234);
    @(posedge clk);
    push_text(tfv_pkg::KIND_USER, "");
    push_text(tfv_pkg::KIND_PASS, "");
    push_text(tfv_pkg::KIND_MESSAGE, "a");
    push_text(tfv_pkg::KIND_GROUP, "");
    push_text(tfv_pkg::KIND_GROUP, "a");
    push_text(tfv_pkg::KIND_USER, "abc");
    random_round(40);
    drain();

    // minimum above maximum
    write_limit(tfv_pkg::REG_USER_MIN, 16'd5);
    write_limit(tfv_pkg::REG_USER_MAX, 16'd2);
    write_limit(tfv_pkg::REG_PASS_MIN, 16'd8);
    write_limit(tfv_pkg::REG_PASS_MAX, 16'd3);
    write_limit(tfv_pkg::REG_MSG_MAX, 16'hFFFF);
    write_limit(tfv_pkg::REG_GROUP_MIN, 16'd4);
    write_limit(tfv_pkg::REG_GROUP_MAX, 16'd1);
    @(posedge clk);
    random_round(60);
    drain();

    for (int r = 0; r < 4; r++) begin
      random_limits();
      if ($urandom_range(0, 3) == 0) write_limit(REG_NONE, limit_t'($urandom_range(0, 65535)));
      @(posedge clk);
      pace_on = (r != 2);
      random_round(50);
      drain();
    end

    if (mismatches == 0) begin
      $display("text_field_validator test passed");
    end else begin
      $display("text_field_validator test failed");
    end
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("text_field_validator test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tfv_pkg.sv
rtl/tfv_if.sv
rtl/text_field_validator.sv
sim/tb.sv
